[rtl/fqed_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fqed_pkg;

  // Samples held in each channel's filter window (1 to 32).
  localparam int unsigned Window = 8;

  // Width of the phase and button timers and of every configuration register.
  localparam int unsigned TickW = 16;

  // Configuration port.
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegIdleHoldoff   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOneLowTimeout = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBothLowTimeout = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOneHighTimeout = 3'd3;
  localparam logic [CfgIdxW-1:0] RegButtonDebounce = 3'd4;

  localparam logic [TickW-1:0] IdleHoldoffRst    = 16'd15;
  localparam logic [TickW-1:0] OneLowTimeoutRst  = 16'd2000;
  localparam logic [TickW-1:0] BothLowTimeoutRst = 16'd1100;
  localparam logic [TickW-1:0] OneHighTimeoutRst = 16'd400;
  localparam logic [TickW-1:0] ButtonDebounceRst = 16'd3000;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 8;

  typedef struct packed {
    logic [TickW-1:0] idle_holdoff_ticks;
    logic [TickW-1:0] one_low_timeout_ticks;
    logic [TickW-1:0] both_low_timeout_ticks;
    logic [TickW-1:0] one_high_timeout_ticks;
    logic [TickW-1:0] button_debounce_ticks;
  } cfg_t;

  typedef struct packed {
    logic button_level;
    logic b_level;
    logic a_level;
  } sample_t;

  typedef struct packed {
    logic button_released;
    logic turn_ccw;
    logic turn_cw;
  } result_t;

endpackage

`default_nettype wire

[rtl/fqed_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Decoder state and the per-tick update. The result is combinational from
// the sample and the current state; the state advances when step_i is high.
module fqed_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire fqed_pkg::sample_t    sample_i,
  input  wire fqed_pkg::cfg_t       cfg_i,
  output fqed_pkg::result_t         res_o
);

  localparam logic [2:0] PhIdle     = 3'd0;
  localparam logic [2:0] PhOneLow   = 3'd1;
  localparam logic [2:0] PhBothLow  = 3'd2;
  localparam logic [2:0] PhOneHigh  = 3'd3;
  localparam logic [2:0] PhBothHigh = 3'd4;

  logic [fqed_pkg::Window-1:0] win_a_q, win_a_d, win_b_q, win_b_d;
  logic                        filt_a_q, filt_a_d, filt_b_q, filt_b_d;
  logic [2:0]                  phase_q, phase_d;
  logic                        b_first_q, b_first_d;
  logic [fqed_pkg::TickW-1:0]  phase_ticks_q, phase_ticks_d;
  logic                        btn_prev_q, btn_prev_d;
  logic [fqed_pkg::TickW-1:0]  btn_ticks_q, btn_ticks_d;

  always_comb begin
    logic done;
    logic a_zero, b_zero;
    logic pressed;
    done      = 1'b0;
    res_o     = '0;
    pressed   = ~sample_i.button_level;

    phase_ticks_d = (phase_ticks_q != '1) ? phase_ticks_q + 1'b1 : phase_ticks_q;
    btn_ticks_d   = (btn_ticks_q != '1) ? btn_ticks_q + 1'b1 : btn_ticks_q;

    win_a_d = (win_a_q << 1) | fqed_pkg::Window'(sample_i.a_level);
    win_b_d = (win_b_q << 1) | fqed_pkg::Window'(sample_i.b_level);
    a_zero  = ~|win_a_d;
    b_zero  = ~|win_b_d;

    filt_a_d  = filt_a_q;
    filt_b_d  = filt_b_q;
    phase_d   = phase_q;
    b_first_d = b_first_q;

    if (&win_b_d) filt_b_d = 1'b1;
    if (&win_a_d) filt_a_d = 1'b1;

    // B is tested first, so a simultaneous fall counts as B first.
    if (b_zero) begin
      filt_b_d = 1'b0;
      if (phase_d == PhIdle && phase_ticks_d > cfg_i.idle_holdoff_ticks && filt_a_d) begin
        b_first_d     = 1'b1;
        phase_d       = PhOneLow;
        phase_ticks_d = '0;
      end
    end
    if (a_zero) begin
      filt_a_d = 1'b0;
      if (phase_d == PhIdle && phase_ticks_d > cfg_i.idle_holdoff_ticks && filt_b_d) begin
        b_first_d     = 1'b0;
        phase_d       = PhOneLow;
        phase_ticks_d = '0;
      end
    end

    // The phases are tested in order and may fall through within a tick.
    if (phase_d == PhOneLow) begin
      priority if (phase_ticks_d >= cfg_i.one_low_timeout_ticks) begin
        phase_d = PhIdle; phase_ticks_d = '0; done = 1'b1;
      end else if (b_first_d && filt_b_d) begin
        phase_d = PhIdle; phase_ticks_d = '0; done = 1'b1;
      end else if (!b_first_d && filt_a_d) begin
        phase_d = PhIdle; phase_ticks_d = '0; done = 1'b1;
      end else if (!filt_b_d && !filt_a_d) begin
        phase_d = PhBothLow; phase_ticks_d = '0;
      end else begin
      end
    end

    if (!done && phase_d == PhBothLow) begin
      priority if (phase_ticks_d >= cfg_i.both_low_timeout_ticks) begin
        phase_d = PhIdle; phase_ticks_d = '0; done = 1'b1;
      end else if (filt_a_d && filt_b_d) begin
        phase_d = PhBothHigh; phase_ticks_d = '0;
      end else if (b_first_d && filt_a_d) begin
        phase_d = PhOneLow; phase_ticks_d = '0;
      end else if (!b_first_d && filt_b_d) begin
        phase_d = PhOneLow; phase_ticks_d = '0;
      end else if (b_first_d && filt_b_d) begin
        phase_d = PhOneHigh; phase_ticks_d = '0;
      end else if (!b_first_d && filt_a_d) begin
        phase_d = PhOneHigh; phase_ticks_d = '0;
      end else begin
      end
    end

    if (!done && phase_d == PhOneHigh) begin
      priority if (phase_ticks_d >= cfg_i.one_high_timeout_ticks) begin
        phase_d = PhIdle; phase_ticks_d = '0; done = 1'b1;
      end else if (b_first_d && !filt_b_d) begin
        phase_d = PhBothLow; phase_ticks_d = '0;
      end else if (!b_first_d && !filt_a_d) begin
        phase_d = PhBothLow; phase_ticks_d = '0;
      end else if (b_first_d && !a_zero) begin
        phase_d = PhBothHigh; phase_ticks_d = '0;
      end else if (!b_first_d && !b_zero) begin
        phase_d = PhBothHigh; phase_ticks_d = '0;
      end else begin
      end
    end

    if (!done && phase_d == PhBothHigh) begin
      phase_d        = PhIdle;
      phase_ticks_d  = '0;
      res_o.turn_cw  = b_first_d;
      res_o.turn_ccw = ~b_first_d;
    end

    if (btn_prev_q && !pressed && btn_ticks_d >= cfg_i.button_debounce_ticks) begin
      res_o.button_released = 1'b1;
      btn_ticks_d           = '0;
    end
    btn_prev_d = pressed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_a_q       <= '1;
      win_b_q       <= '1;
      filt_a_q      <= 1'b1;
      filt_b_q      <= 1'b1;
      phase_q       <= PhIdle;
      b_first_q     <= 1'b0;
      phase_ticks_q <= '0;
      btn_prev_q    <= 1'b0;
      btn_ticks_q   <= '0;
    end else if (step_i) begin
      win_a_q       <= win_a_d;
      win_b_q       <= win_b_d;
      filt_a_q      <= filt_a_d;
      filt_b_q      <= filt_b_d;
      phase_q       <= phase_d;
      b_first_q     <= b_first_d;
      phase_ticks_q <= phase_ticks_d;
      btn_prev_q    <= btn_prev_d;
      btn_ticks_q   <= btn_ticks_d;
    end
  end

endmodule

`default_nettype wire

[rtl/filtered_quadrature_encoder_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none

// Rotary encoder decoder with channel filtering and push button debounce.
// Each input stream transaction is one sample tick carrying the raw
// active-low levels of channels A and B and of the button. Each tick yields
// exactly one output transaction with three pulse flags: a clockwise detent,
// a counter-clockwise detent and a debounced button release. All flags are
// zero in a tick without an event.
// An accepted sample lands in an input register; once the result register is
// free the decoder logic works on it, updates its state and writes the result
// register. One sample per clock is sustained while the receiver takes every
// result; the result register and the input register together decouple the
// two sides, so a new sample is still taken while a finished result waits for
// the receiver. When the receiver stalls with both registers full,
// s_axis_tready drops until the result is taken. Reset clears both registers,
// returns the decoder to idle with all-high filter windows and loads the
// register defaults. The configuration port is always ready and should be
// written only while no sample is in flight.
module filtered_quadrature_encoder_decoder (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Sample stream.
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // Bits from 0: a_level, b_level, button_level, zero padding.
  input  wire logic [fqed_pkg::InDataW-1:0]     s_axis_tdata,
  // Result stream.
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // Bits from 0: turn_cw, turn_ccw, button_released, zero padding.
  output logic [fqed_pkg::OutDataW-1:0]         m_axis_tdata,
  // Configuration writes.
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [fqed_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [fqed_pkg::TickW-1:0]       cfg_data_i
);

  fqed_pkg::cfg_t    cfg_q, cfg_d;
  logic              in_valid_q, in_valid_d;
  fqed_pkg::sample_t in_sample_q;
  logic              out_valid_q, out_valid_d;
  fqed_pkg::result_t out_res_q;
  fqed_pkg::result_t core_res;
  logic              out_free;
  logic              advance;

  // The result register can be loaded when empty or being drained this cycle.
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign advance       = in_valid_q & out_free;
  assign s_axis_tready = ~in_valid_q | out_free;
  assign in_valid_d    = s_axis_tready ? s_axis_tvalid : in_valid_q;
  assign out_valid_d   = out_free ? in_valid_q : out_valid_q;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = fqed_pkg::OutDataW'(out_res_q);
  assign cfg_ready_o   = 1'b1;

  // Writes to indexes beyond the register list are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fqed_pkg::RegIdleHoldoff:    cfg_d.idle_holdoff_ticks     = cfg_data_i;
        fqed_pkg::RegOneLowTimeout:  cfg_d.one_low_timeout_ticks  = cfg_data_i;
        fqed_pkg::RegBothLowTimeout: cfg_d.both_low_timeout_ticks = cfg_data_i;
        fqed_pkg::RegOneHighTimeout: cfg_d.one_high_timeout_ticks = cfg_data_i;
        fqed_pkg::RegButtonDebounce: cfg_d.button_debounce_ticks  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_holdoff_ticks     <= fqed_pkg::IdleHoldoffRst;
      cfg_q.one_low_timeout_ticks  <= fqed_pkg::OneLowTimeoutRst;
      cfg_q.both_low_timeout_ticks <= fqed_pkg::BothLowTimeoutRst;
      cfg_q.one_high_timeout_ticks <= fqed_pkg::OneHighTimeoutRst;
      cfg_q.button_debounce_ticks  <= fqed_pkg::ButtonDebounceRst;
      in_valid_q                   <= 1'b0;
      out_valid_q                  <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_sample_q <= fqed_pkg::sample_t'(s_axis_tdata[2:0]);
    end
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  fqed_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .sample_i (in_sample_q),
    .cfg_i    (cfg_q),
    .res_o    (core_res)
  );

endmodule

`default_nettype wire

[rtl/fqed_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module fqed_assertions (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [fqed_pkg::OutDataW-1:0] m_axis_tdata
);

  // A detent is either clockwise or counter-clockwise, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("both turn directions flagged in one result");

  // Padding bits above the result flags stay zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[fqed_pkg::OutDataW-1:3] == '0))
    else $error("result padding bits not zero");

  // The input side only stalls while a result is stuck at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output back-pressure");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed or dropped");

endmodule

bind filtered_quadrature_encoder_decoder fqed_assertions u_fqed_assertions (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[dv/fqed_checker.sv]
`timescale 1ns / 1ps

// Watches the sample, result and configuration channels of the encoder
// decoder, predicts one result per accepted sample and compares every
// accepted result with the oldest prediction.
module fqed_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_tvalid_i,
  input  wire logic                         s_tready_i,
  // Bits from 0: a_level, b_level, button_level, zero padding.
  input  wire logic [fqed_pkg::InDataW-1:0] s_tdata_i,
  input  wire logic                         m_tvalid_i,
  input  wire logic                         m_tready_i,
  // Bits from 0: turn_cw, turn_ccw, button_released, zero padding.
  input  wire logic [fqed_pkg::OutDataW-1:0] m_tdata_i,
  input  wire logic                         cfg_valid_i,
  input  wire logic                         cfg_ready_i,
  input  wire logic [fqed_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [fqed_pkg::TickW-1:0]   cfg_data_i,
  output int unsigned                       errors_o,
  output int unsigned                       pending_o
);

  import fqed_pkg::*;

  typedef enum logic [2:0] {
    PhIdle,
    PhOneLow,
    PhBothLow,
    PhOneHigh,
    PhBothHigh
  } phase_e;

  cfg_t              cfg_now;
  logic [Window-1:0] win_a;
  logic [Window-1:0] win_b;
  logic              lvl_a;
  logic              lvl_b;
  phase_e            phase;
  logic              b_led;
  logic [TickW-1:0]  phase_age;
  logic              btn_held;
  logic [TickW-1:0]  btn_age;

  result_t     expected_q[$];
  result_t     want;
  result_t     got;
  int unsigned fail_count = 0;

  assign errors_o  = fail_count;
  assign pending_o = expected_q.size();

  function automatic void enter_phase(input phase_e next);
    phase     = next;
    phase_age = '0;
  endfunction

  // Advances the decoder copy by one sample tick and returns its pulses.
  function automatic result_t decode_tick(input sample_t smp);
    result_t res;
    logic    done;
    logic    first_lvl;
    logic    second_lvl;
    logic    second_win_busy;
    logic    pressed;

    res     = '0;
    done    = 1'b0;
    pressed = ~smp.button_level;

    if (phase_age != '1) phase_age = phase_age + 1'b1;
    if (btn_age != '1) btn_age = btn_age + 1'b1;

    win_a = {win_a[Window-2:0], smp.a_level};
    win_b = {win_b[Window-2:0], smp.b_level};

    if (&win_b) lvl_b = 1'b1;
    if (&win_a) lvl_a = 1'b1;
    // B is looked at first, so a simultaneous fall counts as B first.
    if (win_b == '0) begin
      lvl_b = 1'b0;
      if (phase == PhIdle && phase_age > cfg_now.idle_holdoff_ticks && lvl_a) begin
        b_led = 1'b1;
        enter_phase(PhOneLow);
      end
    end
    if (win_a == '0) begin
      lvl_a = 1'b0;
      if (phase == PhIdle && phase_age > cfg_now.idle_holdoff_ticks && lvl_b) begin
        b_led = 1'b0;
        enter_phase(PhOneLow);
      end
    end

    first_lvl       = b_led ? lvl_b : lvl_a;
    second_lvl      = b_led ? lvl_a : lvl_b;
    second_win_busy = b_led ? (win_a != '0) : (win_b != '0);

    if (phase == PhOneLow) begin
      if (phase_age >= cfg_now.one_low_timeout_ticks || first_lvl) begin
        enter_phase(PhIdle);
        done = 1'b1;
      end else if (!lvl_a && !lvl_b) begin
        enter_phase(PhBothLow);
      end
    end
    if (!done && phase == PhBothLow) begin
      if (phase_age >= cfg_now.both_low_timeout_ticks) begin
        enter_phase(PhIdle);
        done = 1'b1;
      end else if (lvl_a && lvl_b) begin
        enter_phase(PhBothHigh);
      end else if (second_lvl) begin
        enter_phase(PhOneLow);
      end else if (first_lvl) begin
        enter_phase(PhOneHigh);
      end
    end
    if (!done && phase == PhOneHigh) begin
      if (phase_age >= cfg_now.one_high_timeout_ticks) begin
        enter_phase(PhIdle);
        done = 1'b1;
      end else if (!first_lvl) begin
        enter_phase(PhBothLow);
      end else if (second_win_busy) begin
        enter_phase(PhBothHigh);
      end
    end
    if (!done && phase == PhBothHigh) begin
      enter_phase(PhIdle);
      if (b_led) res.turn_cw = 1'b1;
      else res.turn_ccw = 1'b1;
    end

    if (btn_held && !pressed && btn_age >= cfg_now.button_debounce_ticks) begin
      res.button_released = 1'b1;
      btn_age = '0;
    end
    btn_held = pressed;
    return res;
  endfunction

  task automatic check_bit(input string name, input logic exp_bit, input logic act_bit);
    if (act_bit !== exp_bit) begin
      $error("%s: expected %0b, actual %0b", name, exp_bit, act_bit);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_now   = '{IdleHoldoffRst, OneLowTimeoutRst, BothLowTimeoutRst,
                    OneHighTimeoutRst, ButtonDebounceRst};
      win_a     = '1;
      win_b     = '1;
      lvl_a     = 1'b1;
      lvl_b     = 1'b1;
      phase     = PhIdle;
      b_led     = 1'b0;
      phase_age = '0;
      btn_held  = 1'b0;
      btn_age   = '0;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegIdleHoldoff:    cfg_now.idle_holdoff_ticks     = cfg_data_i;
          RegOneLowTimeout:  cfg_now.one_low_timeout_ticks  = cfg_data_i;
          RegBothLowTimeout: cfg_now.both_low_timeout_ticks = cfg_data_i;
          RegOneHighTimeout: cfg_now.one_high_timeout_ticks = cfg_data_i;
          RegButtonDebounce: cfg_now.button_debounce_ticks  = cfg_data_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_q.push_back(decode_tick(s_tdata_i[$bits(sample_t)-1:0]));
      end
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[$bits(result_t)-1:0];
        if (expected_q.size() == 0) begin
          $error("result transaction arrived with no sample waiting for it");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_bit("turn_cw", want.turn_cw, got.turn_cw);
          check_bit("turn_ccw", want.turn_ccw, got.turn_ccw);
          check_bit("button_released", want.button_released, got.button_released);
        end
      end
    end
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

// Top of the encoder decoder testbench. This module only makes stimulus:
// it resets the block, programs the registers between phases, offers sample
// transactions and accepts result transactions with random gaps. All
// prediction and comparison happens in the checker instantiated beside the
// block, which hands back its failure count and the number of results still
// owed.
module testbench;

  import fqed_pkg::*;

  localparam int unsigned ClkHalf         = 6;
  localparam int unsigned ResetCycles     = 6;
  // Quiet cycles after the last result is taken, before a register write or
  // the verdict.
  localparam int unsigned SettleCycles    = 4;
  // One long receiver stall, placed mid-run, fills both internal registers.
  localparam int unsigned LongHoldAt      = 200;
  localparam int unsigned LongHoldCycles  = 80;
  // Generous ceiling on the length of the whole run.
  localparam int unsigned TimeLimitCycles = 200_000;

  localparam logic [TickW-1:0]   TickMax        = '1;
  localparam logic [CfgIdxW-1:0] FirstUnusedReg = RegButtonDebounce + 1'b1;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [TickW-1:0]    cfg_data;

  int unsigned failures;
  int unsigned results_pending;

  // Stimulus-side bookkeeping. no_idle switches both sides to back-to-back
  // transactions for a whole phase.
  logic        no_idle = 1'b0;
  logic        btn_lvl = 1'b1;
  int unsigned samples_sent = 0;

  always #(ClkHalf) clk_i = ~clk_i;

  filtered_quadrature_encoder_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  fqed_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .errors_o    (failures),
    .pending_o   (results_pending)
  );

  // Offers one sample transaction after a random gap and returns at the edge
  // where it was taken. Valid stays high when the next gap is zero, so a
  // burst never drops valid between transactions.
  task automatic send_sample(input sample_t smp);
    int unsigned        gap;
    logic [InDataW-1:0] word;
    gap  = no_idle ? 0 : $urandom_range(0, 7);
    word = '0;
    word[$bits(sample_t)-1:0] = smp;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    samples_sent++;
  endtask

  // One tick with the given channel levels. The button wanders on its own so
  // that presses and releases land on every phase of a detent.
  task automatic tick(input logic a, input logic b);
    sample_t smp;
    if ($urandom_range(0, 4) == 0) btn_lvl = ~btn_lvl;
    smp.a_level      = a;
    smp.b_level      = b;
    smp.button_level = btn_lvl;
    send_sample(smp);
  endtask

  // Drops valid, waits until the checker owes nothing and lets the pipeline
  // settle. The sampling at the falling edge keeps this clear of the
  // checker's own updates at the rising edge.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    wait (results_pending == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TickW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // Programs all five registers and then one unused index, which the block
  // has to ignore.
  task automatic apply_cfg(input cfg_t c);
    write_reg(RegIdleHoldoff, c.idle_holdoff_ticks);
    write_reg(RegOneLowTimeout, c.one_low_timeout_ticks);
    write_reg(RegBothLowTimeout, c.both_low_timeout_ticks);
    write_reg(RegOneHighTimeout, c.one_high_timeout_ticks);
    write_reg(RegButtonDebounce, c.button_debounce_ticks);
    write_reg(FirstUnusedReg + CfgIdxW'($urandom_range(0, 2)), TickW'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [TickW-1:0] random_timeout();
    return ($urandom_range(0, 7) == 0) ? TickMax : TickW'($urandom_range(6, 40));
  endfunction

  // Short timeouts and holdoffs, so that detents of a few dozen ticks reach
  // every timeout path now and then.
  function automatic cfg_t random_cfg();
    cfg_t c;
    c.idle_holdoff_ticks     = TickW'($urandom_range(0, 20));
    c.one_low_timeout_ticks  = random_timeout();
    c.both_low_timeout_ticks = random_timeout();
    c.one_high_timeout_ticks = random_timeout();
    c.button_debounce_ticks  = TickW'($urandom_range(0, 40));
    return c;
  endfunction

  // One detent as the five levels of the first and the second falling
  // channel: both high, first low, both low, first back high, both high.
  // A clean detent holds each middle level long enough to fill the filter window;
  // a broken one uses random run lengths, which bounces and times out.
  // Sometimes both channels come back together, skipping the one-high step.
  task automatic turn(input logic b_first, input logic broken);
    int unsigned run_len[5];
    logic        first_lvl;
    logic        second_lvl;
    for (int s = 0; s < 5; s++) begin
      if (broken) run_len[s] = $urandom_range(1, 12);
      else if (s == 0 || s == 4) run_len[s] = $urandom_range(0, 4);
      else run_len[s] = $urandom_range(Window, Window + 3);
    end
    if ($urandom_range(0, 3) == 0) run_len[3] = 0;
    for (int s = 0; s < 5; s++) begin
      first_lvl  = (s == 0 || s >= 3);
      second_lvl = (s <= 1 || s == 4);
      for (int k = 0; k < run_len[s]; k++) begin
        if (b_first) tick(second_lvl, first_lvl);
        else tick(first_lvl, second_lvl);
      end
    end
  endtask

  // Mostly clean detents in both directions, the rest broken detents and
  // plain noise on both channels.
  task automatic random_segment();
    int unsigned pick;
    int unsigned noise_len;
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      turn(pick[0], 1'b0);
    end else if (pick <= 7) begin
      turn(1'($urandom_range(0, 1)), 1'b1);
    end else begin
      noise_len = $urandom_range(1, 12);
      repeat (noise_len) tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_phase(input cfg_t c, input logic burst, input int unsigned count);
    int unsigned target;
    apply_cfg(c);
    no_idle = burst;
    target  = samples_sent + count;
    while (samples_sent < target) random_segment();
    drain();
    no_idle = 1'b0;
  endtask

  // Result side: a random stall before every result transaction, no stall
  // during burst phases, and one long hold-off while the sender keeps going.
  initial begin : result_sink
    int unsigned taken;
    int unsigned stall;
    taken         = 0;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken == LongHoldAt) stall = LongHoldCycles;
      else stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

  initial begin : stimulus
    cfg_t    c;
    sample_t smp;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part, with no holdoff and no debounce so that short sequences
    // already show behavior. First every combination of the three pins,
    // which also presses and releases the button once.
    c = '{'0, OneLowTimeoutRst, BothLowTimeoutRst, OneHighTimeoutRst, '0};
    apply_cfg(c);
    for (int i = 0; i < 8; i++) begin
      smp = i[2:0];
      send_sample(smp);
    end
    // Both channels fall in the same tick, so B counts as first, and both
    // come back together, which goes from both-low straight to the last
    // phase and gives a clockwise pulse.
    smp = '{button_level: 1'b1, b_level: 1'b0, a_level: 1'b0};
    repeat (Window) send_sample(smp);
    smp = '{button_level: 1'b1, b_level: 1'b1, a_level: 1'b1};
    repeat (Window) send_sample(smp);
    drain();

    // Holdoff zero with all timeouts at their maximum and no debounce.
    c = '{'0, TickMax, TickMax, TickMax, '0};
    run_phase(c, 1'b0, 90);
    // Holdoff and debounce at their maximum keep the decoder quiet; this
    // phase also runs both sides without idling.
    c = random_cfg();
    c.idle_holdoff_ticks    = TickMax;
    c.button_debounce_ticks = TickMax;
    run_phase(c, 1'b1, 50);
    // Zero timeouts send every phase back to idle at once.
    c = random_cfg();
    c.idle_holdoff_ticks     = '0;
    c.one_low_timeout_ticks  = '0;
    c.both_low_timeout_ticks = '0;
    c.one_high_timeout_ticks = '0;
    run_phase(c, 1'b0, 80);
    repeat (3) run_phase(random_cfg(), 1'b0, 95);

    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeLimitCycles * 2 * ClkHalf);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[filtered_quadrature_encoder_decoder.f]
rtl/fqed_pkg.sv
rtl/fqed_core.sv
rtl/filtered_quadrature_encoder_decoder.sv
rtl/fqed_checker.sv
dv/fqed_checker.sv
dv/testbench.sv
